// ===== rtl/sha_pkg.sv =====
`default_nettype none

package sha_pkg;

  // one input beat: a padded message word and its block flags
  typedef struct packed {
    logic [31:0] message_word;
    logic        start_message;
    logic        final_block;
  } in_beat_t;

  // one output beat: a digest word
  typedef struct packed {
    logic [31:0] digest_word;
    logic        digest_last;
  } out_beat_t;

  // eight 32-bit words: working variables a..h or the chained hash
  typedef logic [7:0][31:0] vars_t;

  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds     = 64;

  // standard initial hash value
  function automatic logic [31:0] iv_word(input logic [2:0] idx);
    logic [31:0] w;
    case (idx)
      3'd0:    w = 32'h6A09E667;
      3'd1:    w = 32'hBB67AE85;
      3'd2:    w = 32'h3C6EF372;
      3'd3:    w = 32'hA54FF53A;
      3'd4:    w = 32'h510E527F;
      3'd5:    w = 32'h9B05688C;
      3'd6:    w = 32'h1F83D9AB;
      default: w = 32'h5BE0CD19;
    endcase
    return w;
  endfunction

  // round constant table
  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0:  k = 32'h428A2F98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hB5C0FBCF;  6'd3:  k = 32'hE9B5DBA5;
      6'd4:  k = 32'h3956C25B;  6'd5:  k = 32'h59F111F1;
      6'd6:  k = 32'h923F82A4;  6'd7:  k = 32'hAB1C5ED5;
      6'd8:  k = 32'hD807AA98;  6'd9:  k = 32'h12835B01;
      6'd10: k = 32'h243185BE;  6'd11: k = 32'h550C7DC3;
      6'd12: k = 32'h72BE5D74;  6'd13: k = 32'h80DEB1FE;
      6'd14: k = 32'h9BDC06A7;  6'd15: k = 32'hC19BF174;
      6'd16: k = 32'hE49B69C1;  6'd17: k = 32'hEFBE4786;
      6'd18: k = 32'h0FC19DC6;  6'd19: k = 32'h240CA1CC;
      6'd20: k = 32'h2DE92C6F;  6'd21: k = 32'h4A7484AA;
      6'd22: k = 32'h5CB0A9DC;  6'd23: k = 32'h76F988DA;
      6'd24: k = 32'h983E5152;  6'd25: k = 32'hA831C66D;
      6'd26: k = 32'hB00327C8;  6'd27: k = 32'hBF597FC7;
      6'd28: k = 32'hC6E00BF3;  6'd29: k = 32'hD5A79147;
      6'd30: k = 32'h06CA6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27B70A85;  6'd33: k = 32'h2E1B2138;
      6'd34: k = 32'h4D2C6DFC;  6'd35: k = 32'h53380D13;
      6'd36: k = 32'h650A7354;  6'd37: k = 32'h766A0ABB;
      6'd38: k = 32'h81C2C92E;  6'd39: k = 32'h92722C85;
      6'd40: k = 32'hA2BFE8A1;  6'd41: k = 32'hA81A664B;
      6'd42: k = 32'hC24B8B70;  6'd43: k = 32'hC76C51A3;
      6'd44: k = 32'hD192E819;  6'd45: k = 32'hD6990624;
      6'd46: k = 32'hF40E3585;  6'd47: k = 32'h106AA070;
      6'd48: k = 32'h19A4C116;  6'd49: k = 32'h1E376C08;
      6'd50: k = 32'h2748774C;  6'd51: k = 32'h34B0BCB5;
      6'd52: k = 32'h391C0CB3;  6'd53: k = 32'h4ED8AA4A;
      6'd54: k = 32'h5B9CCA4F;  6'd55: k = 32'h682E6FF3;
      6'd56: k = 32'h748F82EE;  6'd57: k = 32'h78A5636F;
      6'd58: k = 32'h84C87814;  6'd59: k = 32'h8CC70208;
      6'd60: k = 32'h90BEFFFA;  6'd61: k = 32'hA4506CEB;
      6'd62: k = 32'hBEF9A3F7;  default: k = 32'hC67178F2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // schedule sigma functions
  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sha_wmem.sv =====
`default_nettype none

module sha_wmem
  import sha_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        we_i,
  input  wire logic [3:0]  waddr_i,
  input  wire logic [31:0] wdata_i,
  input  wire logic [3:0]  raddr_a_i,
  input  wire logic [3:0]  raddr_b_i,
  output logic      [31:0] rdata_a_o,
  output logic      [31:0] rdata_b_o
);

  logic [31:0] mem_q [BlockWords];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // two registered read ports
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

// ===== rtl/sha_round.sv =====
`default_nettype none

module sha_round
  import sha_pkg::*;
(
  input  wire vars_t       v_i,
  input  wire logic [31:0] wt_i,
  input  wire logic [31:0] k_i,
  output vars_t            v_o
);

  logic [31:0] big_s0, big_s1, ch, maj, t1, t2;

  // compression function for one round
  always_comb begin
    big_s1 = rotr(v_i[4], 6) ^ rotr(v_i[4], 11) ^ rotr(v_i[4], 25);
    ch     = (v_i[4] & v_i[5]) ^ (~v_i[4] & v_i[6]);
    t1     = v_i[7] + big_s1 + ch + k_i + wt_i;
    big_s0 = rotr(v_i[0], 2) ^ rotr(v_i[0], 13) ^ rotr(v_i[0], 22);
    maj    = (v_i[0] & v_i[1]) ^ (v_i[0] & v_i[2]) ^ (v_i[1] & v_i[2]);
    t2     = big_s0 + maj;
    v_o[7] = v_i[6];
    v_o[6] = v_i[5];
    v_o[5] = v_i[4];
    v_o[4] = v_i[3] + t1;
    v_o[3] = v_i[2];
    v_o[2] = v_i[1];
    v_o[1] = v_i[0];
    v_o[0] = t1 + t2;
  end

endmodule

`default_nettype wire

// ===== rtl/sha256_block_compress.sv =====
`default_nettype none
// channel   direction  payload     handshake
// in        input      in_beat_t   in_valid_i / in_stall_o
// out       output     out_beat_t  out_valid_o / out_stall_i
//
// words load at one per cycle into the schedule memory; the sixteenth starts a compression
// rounds 0..15 step through read, sum and round; rounds 16..63 add expansion (two reads of
// the dual-port schedule memory, one expansion add, one round), then a chain add per block
// a final block adds 8 digest beats, one per cycle when the output is not stalled
// in_stall_o is high from the sixteenth word until compression and digest output are done
// asynchronous reset loads the initial hash and clears the counters

module sha256_block_compress
  import sha_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire in_beat_t in_data_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  output out_beat_t     out_data_o,
  input  wire logic     out_stall_i
);

  localparam logic [2:0] ST_LOAD = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_EXP  = 3'd3;
  localparam logic [2:0] ST_RND  = 3'd4;
  localparam logic [2:0] ST_ADD  = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0]  state_q, state_d;
  logic [3:0]  word_cnt_q;
  logic [5:0]  round_q;
  logic [2:0]  out_idx_q;
  logic        final_q;
  vars_t       chain_q, vars_q, vars_nxt;
  logic [31:0] psum_q, wt_q, wt_exp;
  logic        out_valid_q;
  out_beat_t   out_q;

  logic        in_acc, out_load;
  logic        we;
  logic [3:0]  waddr, raddr_a, raddr_b;
  logic [31:0] wdata, rdata_a, rdata_b;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  assign in_stall_o  = (state_q != ST_LOAD);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // schedule expansion: w[i-16] + s0(w[i-15]) was summed last cycle
  assign wt_exp = psum_q + rdata_a + ssig1(rdata_b);

  // schedule memory port control
  always_comb begin
    we      = 1'b0;
    waddr   = round_q[3:0];
    wdata   = wt_exp;
    raddr_a = round_q[3:0];
    raddr_b = round_q[3:0] + 4'd1;
    case (state_q)
      ST_LOAD: begin
        we    = in_acc;
        waddr = word_cnt_q;
        wdata = in_data_i.message_word;
      end
      ST_SUM: begin
        raddr_a = round_q[3:0] + 4'd9;
        raddr_b = round_q[3:0] + 4'd14;
      end
      ST_EXP: begin
        we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  sha_wmem u_wmem (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  sha_round u_round (
    .v_i  (vars_q),
    .wt_i (wt_q),
    .k_i  (round_k(round_q)),
    .v_o  (vars_nxt)
  );

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: if (in_acc && word_cnt_q == 4'd15) state_d = ST_RD;
      ST_RD:   state_d = ST_SUM;
      ST_SUM:  state_d = (round_q[5:4] == 2'd0) ? ST_RND : ST_EXP;
      ST_EXP:  state_d = ST_RND;
      ST_RND:  state_d = (round_q == 6'd63) ? ST_ADD : ST_RD;
      ST_ADD:  state_d = final_q ? ST_OUT : ST_LOAD;
      ST_OUT:  if (out_load && out_idx_q == 3'd7) state_d = ST_LOAD;
      default: state_d = ST_LOAD;
    endcase
  end

  // control registers and chained hash
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      word_cnt_q <= '0;
      round_q    <= '0;
      out_idx_q  <= '0;
      final_q    <= 1'b0;
      for (int j = 0; j < 8; j++) begin
        chain_q[j] <= iv_word(3'(j));
      end
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        word_cnt_q <= word_cnt_q + 4'd1;
        if (word_cnt_q == 4'd0 && in_data_i.start_message) begin
          for (int j = 0; j < 8; j++) begin
            chain_q[j] <= iv_word(3'(j));
          end
        end
        if (word_cnt_q == 4'd15) begin
          final_q <= in_data_i.final_block;
        end
      end
      if (state_q == ST_RND) begin
        round_q <= round_q + 6'd1;
      end
      if (state_q == ST_ADD) begin
        for (int j = 0; j < 8; j++) begin
          chain_q[j] <= chain_q[j] + vars_q[j];
        end
      end
      if (out_load) begin
        out_idx_q <= out_idx_q + 3'd1;
      end
    end
  end

  // working variables and schedule word
  always_ff @(posedge clk_i) begin
    if (in_acc && word_cnt_q == 4'd15) begin
      vars_q <= chain_q;
    end else if (state_q == ST_RND) begin
      vars_q <= vars_nxt;
    end
    if (state_q == ST_SUM) begin
      wt_q   <= rdata_a;
      psum_q <= rdata_a + ssig0(rdata_b);
    end
    if (state_q == ST_EXP) begin
      wt_q <= wt_exp;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.digest_word <= chain_q[out_idx_q];
      out_q.digest_last <= (out_idx_q == 3'd7);
    end
  end

  // the last round hands over to the chain add
  a_last_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RND && round_q == 6'd63) |=> (state_q == ST_ADD && round_q == 6'd0))
    else $error("last round did not end the compression");

  // the sixteenth word starts round zero
  a_block_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && word_cnt_q == 4'd15) |=> (state_q == ST_RD && round_q == 6'd0))
    else $error("compression did not start at round zero");

  // schedule memory is written only by input beats or expansion
  a_mem_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> ((state_q == ST_LOAD && in_acc) || state_q == ST_EXP))
    else $error("unexpected schedule memory write");

  // loading the eighth digest word flags it last and reopens input
  a_digest_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_idx_q == 3'd7) |=> (out_valid_q && out_q.digest_last && !in_stall_o))
    else $error("digest sequence ended wrongly");

endmodule

`default_nettype wire
